@@ design/mcks_pkg.sv @@
// Shared types, constants and round helper for the Magma counter-mode keystream cipher.
`default_nettype none
package mcks_pkg;

  localparam int ROUNDS     = 32;
  localparam int FWD_ROUNDS = 24;
  localparam int ROT_LEFT   = 11;
  localparam int ROT_RIGHT  = 21;
  localparam int KEY_WORDS  = 8;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_01    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_23    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_45    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_67    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CTR_START = 3'd4;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  typedef struct packed {
    logic [63:0] data_in;
    logic [3:0]  byte_count;
    logic        start_req;
  } in_word_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [3:0]  count_out;
  } out_word_t;

  // One slot of the round chain: counter halves in flight plus the data riding along.
  typedef struct packed {
    logic        valid;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] data;
    logic [3:0]  cnt;
  } cell_word_t;

  function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [31:0] k);
    logic [31:0] t;
    logic [31:0] s;
    t = half + k;
    for (int i = 0; i < 8; i++) begin
      s[4*i +: 4] = SBOX[i][t[4*i +: 4]];
    end
    return (s << ROT_LEFT) | (s >> ROT_RIGHT);
  endfunction

endpackage
`default_nettype wire

@@ design/mcks_round_cell.sv @@
// One Magma round cell of the keystream chain, registered at its output.
`default_nettype none
module mcks_round_cell
  import mcks_pkg::*;
#(
  parameter bit LAST_ROUND = 1'b0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [31:0] round_key,
  input  wire cell_word_t  cell_in,
  output cell_word_t       cell_out
);

  cell_word_t  cell_next;
  logic [31:0] mix;

  always_comb begin
    mix       = round_fn(cell_in.lo, round_key) ^ cell_in.hi;
    cell_next = cell_in;
    if (LAST_ROUND) begin
      // final round: no half swap
      cell_next.hi = mix;
    end else begin
      cell_next.hi = cell_in.lo;
      cell_next.lo = mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule
`default_nettype wire

@@ design/magma_ctr_keystream_cipher_top.sv @@
// Top level of the Magma counter-mode keystream cipher: counter, round chain, output stage.
// A word passes 32 registered round cells and 1 registered output stage to its result word.
// Throughput: one word per cycle; the unrolled chain of 32 round cells advances as a whole
// and holds only while a finished result word waits under out_stall.
// Reset (rst, synchronous): clears the counter, all key and counter_start registers, and
// every valid flag in the chain; no clearing pass, the block accepts words the next cycle.
`default_nettype none
module magma_ctr_keystream_cipher_top
  import mcks_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_word_t               in_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_word_t                   out_word
);

  // Configuration registers.
  logic [63:0] key_01;
  logic [63:0] key_23;
  logic [63:0] key_45;
  logic [63:0] key_67;
  logic [63:0] counter_start;

  // Running counter.
  logic [63:0] counter;
  logic [63:0] ctr_cur;

  logic        en;
  logic        in_accept;
  logic [31:0] key_word [KEY_WORDS];

  cell_word_t  chain [ROUNDS+1];

  logic [3:0]  clip_cnt;
  logic [63:0] keep_mask;
  out_word_t   out_word_next;

  // Write configuration; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_01        <= '0;
      key_23        <= '0;
      key_45        <= '0;
      key_67        <= '0;
      counter_start <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_01:    key_01        <= cfg_data;
        REG_KEY_23:    key_23        <= cfg_data;
        REG_KEY_45:    key_45        <= cfg_data;
        REG_KEY_67:    key_67        <= cfg_data;
        REG_CTR_START: counter_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split key pairs into words: even word in the upper half.
  assign key_word[0] = key_01[63:32];
  assign key_word[1] = key_01[31:0];
  assign key_word[2] = key_23[63:32];
  assign key_word[3] = key_23[31:0];
  assign key_word[4] = key_45[63:32];
  assign key_word[5] = key_45[31:0];
  assign key_word[6] = key_67[63:32];
  assign key_word[7] = key_67[31:0];

  // The whole chain moves together; hold it only while a result waits to be taken.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign in_accept = in_valid && en;

  // Reload the counter on a start request, then advance it once per accepted word.
  assign ctr_cur = in_word.start_req ? counter_start : counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (in_accept) begin
      counter <= ctr_cur + 64'd1;
    end
  end

  // Feed the head of the chain; an idle cycle enters as a bubble.
  always_comb begin
    chain[0].valid = in_valid;
    chain[0].hi    = ctr_cur[63:32];
    chain[0].lo    = ctr_cur[31:0];
    chain[0].data  = in_word.data_in;
    chain[0].cnt   = in_word.byte_count;
  end

  // Round chain: key words 0..7 three times, then 7..0.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int KeyIdx = (r < FWD_ROUNDS) ? (r % KEY_WORDS) : (ROUNDS - 1 - r);
    mcks_round_cell #(
      .LAST_ROUND(r == ROUNDS - 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .round_key(key_word[KeyIdx]),
      .cell_in  (chain[r]),
      .cell_out (chain[r+1])
    );
  end

  // Output stage: XOR with the keystream, keep the leading bytes, zero the rest.
  // Counts above eight keep all bytes; count_out still copies the input count.
  always_comb begin
    clip_cnt = (chain[ROUNDS].cnt > 4'd8) ? 4'd8 : chain[ROUNDS].cnt;
    for (int b = 0; b < 8; b++) begin
      keep_mask[63 - 8*b -: 8] = (4'(b) < clip_cnt) ? 8'hFF : 8'h00;
    end
    out_word_next.data_out  = (chain[ROUNDS].data ^ {chain[ROUNDS].hi, chain[ROUNDS].lo})
                              & keep_mask;
    out_word_next.count_out = chain[ROUNDS].cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= out_word_next;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the Magma counter-mode keystream cipher top level.
module tb_top;
  import mcks_pkg::*;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off that fills the round chain
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 40;    // idle time after the last result word, longer than the chain's latency
  localparam int PHASE_WORDS    = 345;   // random words per idling phase, four phases

  // One directed word; typed rows carry a result that is obvious by inspection.
  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        start;
    bit          typed;
    logic [63:0] exp_data;
    logic [3:0]  exp_cnt;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_word;

  // Own copy of the GOST R 34.12-2015 substitution table, row i serves nibble i.
  logic [3:0] gost_sbox [8][16] = '{
    '{12, 4, 6, 2, 10, 5, 11, 9, 14, 8, 13, 7, 0, 3, 15, 1},
    '{6, 8, 2, 3, 9, 10, 5, 12, 1, 14, 4, 7, 11, 13, 0, 15},
    '{11, 3, 5, 8, 2, 15, 10, 13, 14, 1, 7, 4, 12, 9, 6, 0},
    '{12, 8, 2, 1, 13, 4, 15, 6, 7, 0, 10, 5, 3, 14, 9, 11},
    '{7, 15, 5, 10, 8, 1, 6, 13, 0, 9, 3, 14, 11, 4, 2, 12},
    '{5, 13, 15, 6, 9, 2, 12, 10, 11, 7, 8, 1, 4, 3, 14, 0},
    '{8, 14, 2, 5, 6, 9, 1, 12, 15, 4, 11, 0, 13, 10, 3, 7},
    '{1, 7, 14, 13, 0, 5, 8, 3, 4, 15, 10, 6, 9, 12, 11, 2}
  };

  // Directed words. Rows 0..8 run on the reset register values, rows 9..10 on the
  // standard test key, rows 11..14 on an all-ones key with the counter at all ones.
  stim_row_t dir_rows [15] = '{
    '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},                   // zero key, zero counter
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1, 64'h0, 4'd0}, // no bytes: word blanked
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b0, 1'b0, 64'h0, 4'd0}, // count above eight
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 1'b1, 64'h0, 4'd0}, // reload on an empty word
    '{64'hA5A5_A5A5_5A5A_5A5A, 4'd4, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h0, 4'd8, 1'b1, 1'b0, 64'h0, 4'd0},                   // standard key and block
    '{64'hFEDC_BA98_7654_3210, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h0, 4'd8, 1'b1, 1'b0, 64'h0, 4'd0},                   // counter at all ones
    '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0, 4'd0},                   // counter wrapped to zero
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0, 1'b0, 64'h0, 4'd0},
    '{64'h8000_0000_0000_0001, 4'd15, 1'b1, 1'b0, 64'h0, 4'd0}
  };

  // Predictor state: key pairs, reload value and the running counter.
  logic [63:0] key_pair [4];
  logic [63:0] ctr_reload;
  logic [63:0] ctr_model;

  out_word_t pending_words [$];  // expected result words, oldest first
  out_word_t want;
  int        mismatches;
  int        send_idle_pct;
  int        stall_pct;
  bit        hold_req;
  int        idle_cycles = 0;

  magma_ctr_keystream_cipher_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  // Key word 0 sits in the upper half of the first pair, word 7 in the lower half of the last.
  function automatic logic [31:0] key_word(input int idx);
    return idx[0] ? key_pair[idx >> 1][31:0] : key_pair[idx >> 1][63:32];
  endfunction

  // One Feistel round function: add the key, substitute every nibble, rotate left by 11.
  function automatic logic [31:0] magma_f(input logic [31:0] half, input logic [31:0] k);
    logic [31:0] t;
    logic [31:0] s;
    t = half + k;
    for (int i = 0; i < 8; i++) begin
      s[4*i +: 4] = gost_sbox[i][t[4*i +: 4]];
    end
    return {s[20:0], s[31:21]};
  endfunction

  // 32 rounds, keys 0..7 three times then 7..0; the last round leaves the halves in place.
  function automatic logic [63:0] magma_block_encrypt(input logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] nv;
    int          kidx;
    hi = blk[63:32];
    lo = blk[31:0];
    for (int r = 0; r < 32; r++) begin
      kidx = (r < 24) ? (r % 8) : (31 - r);
      nv = magma_f(lo, key_word(kidx)) ^ hi;
      if (r == 31) begin
        hi = nv;
      end else begin
        hi = lo;
        lo = nv;
      end
    end
    return {hi, lo};
  endfunction

  // Advance the predicted counter by one word and return the result word it yields.
  function automatic out_word_t ctr_encrypt_word(input in_word_t w);
    out_word_t   res;
    logic [63:0] mask;
    int          nbytes;
    if (w.start_req) begin
      ctr_model = ctr_reload;
    end
    nbytes = (w.byte_count > 4'd8) ? 8 : int'(w.byte_count);
    mask = (nbytes == 8) ? {64{1'b1}} : ~({64{1'b1}} >> (8 * nbytes));
    res.data_out  = (w.data_in ^ magma_block_encrypt(ctr_model)) & mask;
    res.count_out = w.byte_count;
    ctr_model = ctr_model + 64'd1;
    return res;
  endfunction

  // Random word: mostly full blocks with random data, some short, empty or oversized counts,
  // and an occasional counter reload.
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(9);
    case (pick)
      0: w.data_in = 64'h0;
      1: w.data_in = {64{1'b1}};
      2: w.data_in = 64'd1 << $urandom_range(63);
      default: w.data_in = {$urandom, $urandom};
    endcase
    w.byte_count = $urandom_range(1) ? 4'd8 : 4'($urandom_range(15));
    w.start_req  = ($urandom_range(19) == 0);
    return w;
  endfunction

  // Drive one register write; the caller lowers the write enable after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_KEY_01:    key_pair[0] = value;
      REG_KEY_23:    key_pair[1] = value;
      REG_KEY_45:    key_pair[2] = value;
      REG_KEY_67:    key_pair[3] = value;
      REG_CTR_START: ctr_reload  = value;
      default: ;
    endcase
  endtask

  // Write all five registers back to back; only called while the block is empty.
  task automatic load_config(input logic [63:0] k01, input logic [63:0] k23,
                             input logic [63:0] k45, input logic [63:0] k67,
                             input logic [63:0] start_val);
    write_reg(REG_KEY_01, k01);
    write_reg(REG_KEY_23, k23);
    write_reg(REG_KEY_45, k45);
    write_reg(REG_KEY_67, k67);
    write_reg(REG_CTR_START, start_val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word, idling first at the current rate, and hold it until accepted.
  // Typed rows push their hand-written result; the predictor still advances its counter.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    res = ctr_encrypt_word(w);
    pending_words.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and wait until every expected word has come back; waits at least one edge
  // so that valid is never lowered and raised in the same step.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic walk_rows(input int first, input int last);
    in_word_t  w;
    out_word_t typed_res;
    for (int i = first; i <= last; i++) begin
      w.data_in           = dir_rows[i].data;
      w.byte_count        = dir_rows[i].cnt;
      w.start_req         = dir_rows[i].start;
      typed_res.data_out  = dir_rows[i].exp_data;
      typed_res.count_out = dir_rows[i].exp_cnt;
      send_word(w, dir_rows[i].typed, typed_res);
    end
  endtask

  // Sender: directed table first, then four random phases with different idling.
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_word       = '0;
    key_pair      = '{default: 64'h0};
    ctr_reload    = 64'h0;
    ctr_model     = 64'h0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: zero key, counter starting at zero.
    walk_rows(0, 8);
    wait_results_done();

    // Standard test key with the standard test block as the counter.
    load_config(64'hFFEE_DDCC_BBAA_9988, 64'h7766_5544_3322_1100,
                64'hF0F1_F2F3_F4F5_F6F7, 64'hF8F9_FAFB_FCFD_FEFF, 64'hFEDC_BA98_7654_3210);
    walk_rows(9, 10);
    wait_results_done();

    // All-ones key; counter loaded at all ones so the next word wraps it.
    load_config({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    walk_rows(11, 14);

    for (int p = 0; p < 4; p++) begin
      wait_results_done();
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        end
        1: begin
          send_idle_pct = 48;
          stall_pct     = 0;
          load_config(64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 48;
          load_config({$urandom, $urandom}, {$urandom, $urandom}, {64{1'b1}},
                      64'h0, {$urandom, $urandom});
        end
        default: begin
          send_idle_pct = 22;
          stall_pct     = 22;
          // Reloads land close to the top so the counter keeps wrapping.
          load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {64{1'b1}} - 64'($urandom_range(200)));
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Hold the receiver off for a long stretch while words keep coming,
        // then later pause the sender until the chain has fully drained.
        if (p == 0 && n == 100) begin
          hold_req = 1'b1;
        end
        if (p == 0 && n == 250) begin
          wait_results_done();
        end
        send_word(random_word(), 1'b0, '0);
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stall at the phase rate, or a long hold-off counted here on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !rst && ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every accepted result word with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: unexpected result word, expected none, got data_out %h count_out %h",
                 $time, out_word.data_out, out_word.count_out);
      end else begin
        want = pending_words.pop_front();
        if (out_word.data_out !== want.data_out) begin
          mismatches = mismatches + 1;
          $display("%0t: data_out mismatch, expected %h, got %h",
                   $time, want.data_out, out_word.data_out);
        end
        if (out_word.count_out !== want.count_out) begin
          mismatches = mismatches + 1;
          $display("%0t: count_out mismatch, expected %h, got %h",
                   $time, want.count_out, out_word.count_out);
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
design/mcks_pkg.sv
design/mcks_round_cell.sv
design/magma_ctr_keystream_cipher_top.sv
bench/tb_top.sv
